/* design/dahdsr_envelope_generator_defines.svh */
// Assertion macros used by the envelope generator source.
`ifndef DAHDSR_ENVELOPE_GENERATOR_DEFINES_SVH
`define DAHDSR_ENVELOPE_GENERATOR_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define DAHDSR_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define DAHDSR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/dahdsr_pkg.sv */
// Shared types, codes and field widths of the DAHDSR envelope generator.
package dahdsr_pkg;

    localparam int CMD_W      = 2;
    localparam int Q_W        = 25;
    localparam int STAGE_W    = 3;
    localparam int COEFF_W    = 24;
    localparam int CNT_REG_W  = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 25;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK     = 2'd0,
        CMD_NOTE_ON  = 2'd1,
        CMD_NOTE_OFF = 2'd2
    } t_cmd;

    typedef enum logic [STAGE_W-1:0] {
        STG_IDLE    = 3'd0,
        STG_DELAY   = 3'd1,
        STG_ATTACK  = 3'd2,
        STG_HOLD    = 3'd3,
        STG_DECAY   = 3'd4,
        STG_SUSTAIN = 3'd5,
        STG_RELEASE = 3'd6
    } t_stage;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ATTACK_COEFF  = 3'd0,
        CFG_DECAY_COEFF   = 3'd1,
        CFG_RELEASE_COEFF = 3'd2,
        CFG_SUSTAIN_LEVEL = 3'd3,
        CFG_DELAY_COUNT   = 3'd4,
        CFG_HOLD_COUNT    = 3'd5
    } t_cfg_idx;

endpackage

/* design/dahdsr_cmd_if.sv */
// Event channel carrying envelope commands and note velocity.
interface dahdsr_cmd_if
    import dahdsr_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [CMD_W-1:0]     command;
    logic [Q_W-1:0]       velocity;

    modport source (output valid, output command, output velocity, input ready);
    modport sink (input valid, input command, input velocity, output ready);
endinterface

/* design/dahdsr_env_if.sv */
// Result channel carrying the envelope level and the current stage.
interface dahdsr_env_if
    import dahdsr_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [Q_W-1:0]       level;
    logic [STAGE_W-1:0]   stage;

    modport source (output valid, output level, output stage, input ready);
    modport sink (input valid, input level, input stage, output ready);
endinterface

/* design/dahdsr_envelope_generator.sv */
// DAHDSR envelope generator with exponential segments and a serial multiplier.
//
// Channel  Dir  Payload                 One request is
// i_cmd    in   command, velocity       a tick, a note on or a note off
// o_env    out  level, stage            the envelope sample of one tick
// cfg      in   i_cfg_idx, i_cfg_data   one register write while i_cfg_we is high
//
// A tick in attack, decay or release runs three shift-add products of FRAC_BITS+1 steps
// each in one serial multiplier; a tick in hold or sustain runs one, in delay or idle none.
// A note event is taken in the wait step. Reset is synchronous; it restores the sequencer,
// stage, configuration and output registers, but not the multiplier data or products.
// A stalled o_env request holds the sequencer in its emit step with i_cmd not ready.
`include "dahdsr_envelope_generator_defines.svh"
module dahdsr_envelope_generator
    import dahdsr_pkg::*;
#(
    parameter int FRAC_BITS  = 24,
    parameter int COUNT_BITS = 24
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    dahdsr_cmd_if.sink            i_cmd,
    dahdsr_env_if.source          o_env
);

    localparam int F     = FRAC_BITS;
    localparam int W_B   = F + 1;
    localparam int W_M   = F + 2;
    localparam int W_P   = W_M + W_B;
    localparam int W_Q   = W_P - F;
    localparam int W_R   = W_Q + 1;
    localparam int W_E   = F + 3;
    localparam int W_C   = COUNT_BITS;
    localparam int W_CC  = (W_C > CNT_REG_W) ? W_C : CNT_REG_W;
    localparam int W_CX  = (W_B > COEFF_W) ? W_B : COEFF_W;
    localparam int W_SX  = (W_B > Q_W) ? W_B : Q_W;
    localparam int W_CNT = $clog2(W_B + 1);

    localparam longint ONE_L = longint'(1) << F;
    localparam longint ATR_L = (3 * ONE_L + 5) / 10;
    localparam longint DTR_L = (ONE_L + 5000) / 10000;
    localparam longint EPS_L = (ONE_L + 50000) / 100000;

    localparam logic signed [W_R-1:0] ONE_R     = W_R'(ONE_L);
    localparam logic signed [W_R-1:0] ONE_ATR_R = W_R'(ONE_L + ATR_L);
    localparam logic signed [W_R-1:0] DTR_R     = W_R'(DTR_L);
    localparam logic signed [W_R-1:0] NDTR_R    = W_R'(-DTR_L);
    localparam logic signed [W_R-1:0] EPS_R     = W_R'(EPS_L);
    localparam logic signed [W_E-1:0] ONE_E     = W_E'(ONE_L);
    localparam logic [W_B-1:0]        ONE_B     = W_B'(ONE_L);
    localparam logic [W_CX-1:0]       ONE_CX    = W_CX'(ONE_L);
    localparam logic [W_SX-1:0]       ONE_SX    = W_SX'(ONE_L);
    localparam logic [W_C-1:0]        CNT_MAX   = {W_C{1'b1}};
    localparam logic [W_CNT-1:0]      MUL_STEPS = W_CNT'(W_B);

    typedef enum logic [2:0] {
        SQ_WAIT,
        SQ_TICK,
        SQ_BASE,
        SQ_CROSS,
        SQ_UPDATE,
        SQ_LOAD,
        SQ_LEVEL,
        SQ_EMIT
    } t_seq;

    logic [COEFF_W-1:0]   r_attack_coeff, n_attack_coeff;
    logic [COEFF_W-1:0]   r_decay_coeff, n_decay_coeff;
    logic [COEFF_W-1:0]   r_release_coeff, n_release_coeff;
    logic [Q_W-1:0]       r_sustain, n_sustain;
    logic [CNT_REG_W-1:0] r_delay_count, n_delay_count;
    logic [CNT_REG_W-1:0] r_hold_count, n_hold_count;

    t_seq                 r_seq, n_seq;
    t_stage               r_stage, n_stage;
    logic signed [W_E-1:0] r_env, n_env;
    logic [W_C-1:0]       r_count, n_count;
    logic [W_B-1:0]       r_vel, n_vel;
    logic                 r_out_valid, n_out_valid;
    logic [Q_W-1:0]       r_out_level, n_out_level;
    t_stage               r_out_stage, n_out_stage;

    logic [W_M-1:0]       r_mcand;
    logic                 r_mneg;
    logic [W_M-1:0]       r_hi;
    logic [W_B-1:0]       r_lo;
    logic [W_CNT-1:0]     r_cnt;
    logic signed [W_R-1:0] r_base, n_base;
    logic signed [W_R-1:0] r_cross, n_cross;
    logic signed [W_R-1:0] r_lvl, n_lvl;

    logic                 in_acc;
    logic                 out_free;
    logic [COEFF_W-1:0]   coeff_raw;
    logic [W_CX-1:0]      coeff_x;
    logic [W_CX-1:0]      coeff_eff;
    logic [W_B-1:0]       coeff_b;
    logic [W_B-1:0]       one_minus_c;
    logic [W_SX-1:0]      sus_x;
    logic [W_B-1:0]       sus_b;
    logic signed [W_R-1:0] sus_r;
    logic signed [W_E-1:0] sus_e;
    logic [W_SX-1:0]      vel_x;
    logic [W_B-1:0]       vel_sat;
    logic [W_C-1:0]       count_inc;
    logic [CNT_REG_W-1:0] count_tgt;
    logic                 count_done;
    logic signed [W_R-1:0] env_r;
    logic signed [W_R-1:0] base_a;
    logic signed [W_R-1:0] upd;
    logic [W_P-1:0]       prod;
    logic [W_R-1:0]       prod_mag;
    logic                 prod_rb;
    logic signed [W_R-1:0] mul_res;
    logic [W_M:0]         mul_sum;
    logic                 mul_load;
    logic signed [W_R-1:0] mul_a;
    logic [W_B-1:0]       mul_b;
    logic [W_R-1:0]       a_mag;
    logic [W_B-1:0]       lvl_c;
    logic [W_SX-1:0]      lvl_x;

    assign i_cmd.ready = (r_seq == SQ_WAIT);
    assign in_acc      = i_cmd.valid && i_cmd.ready;
    assign out_free    = !r_out_valid || o_env.ready;

    assign o_env.valid = r_out_valid;
    assign o_env.level = r_out_level;
    assign o_env.stage = r_out_stage;

    always_comb begin
        case (r_stage)
            STG_ATTACK: coeff_raw = r_attack_coeff;
            STG_DECAY:  coeff_raw = r_decay_coeff;
            default:    coeff_raw = r_release_coeff;
        endcase
    end

    assign coeff_x     = W_CX'(coeff_raw);
    assign coeff_eff   = (coeff_x >= ONE_CX) ? (ONE_CX - W_CX'(1)) : coeff_x;
    assign coeff_b     = coeff_eff[W_B-1:0];
    assign one_minus_c = ONE_B - coeff_b;

    assign sus_x = W_SX'(r_sustain);
    assign sus_b = (sus_x > ONE_SX) ? ONE_B : sus_x[W_B-1:0];
    assign sus_r = $signed(W_R'(sus_b));
    assign sus_e = $signed(W_E'(sus_b));

    assign vel_x   = W_SX'(i_cmd.velocity);
    assign vel_sat = (vel_x > ONE_SX) ? ONE_B : vel_x[W_B-1:0];

    assign count_inc  = (r_count == CNT_MAX) ? r_count : (r_count + W_C'(1));
    assign count_tgt  = (r_stage == STG_DELAY) ? r_delay_count : r_hold_count;
    assign count_done = (W_CC'(count_inc) >= W_CC'(count_tgt)) || (count_inc == CNT_MAX);

    assign env_r = W_R'(r_env);

    always_comb begin
        case (r_stage)
            STG_ATTACK: base_a = ONE_ATR_R;
            STG_DECAY:  base_a = sus_r - DTR_R;
            default:    base_a = NDTR_R;
        endcase
    end

    assign upd = r_base + r_cross;

    // The product is rounded to nearest with halves away from zero on its magnitude.
    assign prod     = {r_hi, r_lo};
    assign prod_mag = W_R'(prod[W_P-1:F]);
    assign prod_rb  = prod[F-1];
    assign mul_res  = r_mneg ? $signed(~prod_mag + W_R'(!prod_rb))
                             : $signed(prod_mag + W_R'(prod_rb));
    assign mul_sum  = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_mcand} : {(W_M + 1){1'b0}});
    assign a_mag    = mul_a[W_R-1] ? (~mul_a + W_R'(1)) : mul_a;

    always_comb begin
        if (r_lvl[W_R-1]) begin
            lvl_c = '0;
        end else if (r_lvl > ONE_R) begin
            lvl_c = ONE_B;
        end else begin
            lvl_c = r_lvl[W_B-1:0];
        end
    end

    assign lvl_x = W_SX'(lvl_c);

    always_comb begin
        n_attack_coeff  = r_attack_coeff;
        n_decay_coeff   = r_decay_coeff;
        n_release_coeff = r_release_coeff;
        n_sustain       = r_sustain;
        n_delay_count   = r_delay_count;
        n_hold_count    = r_hold_count;
        n_seq           = r_seq;
        n_stage         = r_stage;
        n_env           = r_env;
        n_count         = r_count;
        n_vel           = r_vel;
        n_out_valid     = r_out_valid && !o_env.ready;
        n_out_level     = r_out_level;
        n_out_stage     = r_out_stage;
        n_base          = r_base;
        n_cross         = r_cross;
        n_lvl           = r_lvl;
        mul_load        = 1'b0;
        mul_a           = env_r;
        mul_b           = coeff_b;

        if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_ATTACK_COEFF:  n_attack_coeff  = i_cfg_data[COEFF_W-1:0];
                CFG_DECAY_COEFF:   n_decay_coeff   = i_cfg_data[COEFF_W-1:0];
                CFG_RELEASE_COEFF: n_release_coeff = i_cfg_data[COEFF_W-1:0];
                CFG_SUSTAIN_LEVEL: n_sustain       = i_cfg_data[Q_W-1:0];
                CFG_DELAY_COUNT:   n_delay_count   = i_cfg_data[CNT_REG_W-1:0];
                CFG_HOLD_COUNT:    n_hold_count    = i_cfg_data[CNT_REG_W-1:0];
                default: ;
            endcase
        end

        case (r_seq)
            SQ_WAIT: begin
                if (in_acc) begin
                    case (t_cmd'(i_cmd.command))
                        CMD_TICK: begin
                            n_seq = SQ_TICK;
                        end
                        CMD_NOTE_ON: begin
                            n_vel   = vel_sat;
                            n_stage = (r_delay_count != '0) ? STG_DELAY : STG_ATTACK;
                            n_count = '0;
                        end
                        CMD_NOTE_OFF: begin
                            if (r_stage != STG_IDLE) begin
                                n_stage = STG_RELEASE;
                                n_count = '0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            SQ_TICK: begin
                case (r_stage)
                    STG_DELAY: begin
                        n_count = count_inc;
                        if (count_done) begin
                            n_stage = STG_ATTACK;
                            n_count = '0;
                        end
                        n_lvl = '0;
                        n_seq = SQ_EMIT;
                    end
                    STG_ATTACK, STG_DECAY, STG_RELEASE: begin
                        mul_load = 1'b1;
                        mul_a    = base_a;
                        mul_b    = one_minus_c;
                        n_seq    = SQ_BASE;
                    end
                    STG_HOLD: begin
                        n_env   = ONE_E;
                        n_count = count_inc;
                        if (count_done) begin
                            n_stage = STG_DECAY;
                            n_count = '0;
                        end
                        n_seq = SQ_LOAD;
                    end
                    STG_SUSTAIN: begin
                        n_env = sus_e;
                        n_seq = SQ_LOAD;
                    end
                    default: begin
                        n_stage = STG_IDLE;
                        n_lvl   = '0;
                        n_seq   = SQ_EMIT;
                    end
                endcase
            end
            SQ_BASE: begin
                if (r_cnt == '0) begin
                    n_base   = mul_res;
                    mul_load = 1'b1;
                    mul_a    = env_r;
                    mul_b    = coeff_b;
                    n_seq    = SQ_CROSS;
                end
            end
            SQ_CROSS: begin
                if (r_cnt == '0) begin
                    n_cross = mul_res;
                    n_seq   = SQ_UPDATE;
                end
            end
            SQ_UPDATE: begin
                n_env = upd[W_E-1:0];
                n_seq = SQ_LOAD;
                case (r_stage)
                    STG_ATTACK: begin
                        if (upd >= ONE_R) begin
                            n_env   = ONE_E;
                            n_stage = (r_hold_count != '0) ? STG_HOLD : STG_DECAY;
                            n_count = '0;
                        end
                    end
                    STG_DECAY: begin
                        if (upd <= sus_r + EPS_R) begin
                            n_env   = sus_e;
                            n_stage = STG_SUSTAIN;
                            n_count = '0;
                        end
                    end
                    default: begin
                        if (upd <= EPS_R) begin
                            n_env   = '0;
                            n_stage = STG_IDLE;
                            n_count = '0;
                        end
                    end
                endcase
            end
            SQ_LOAD: begin
                mul_load = 1'b1;
                mul_a    = env_r;
                mul_b    = r_vel;
                n_seq    = SQ_LEVEL;
            end
            SQ_LEVEL: begin
                if (r_cnt == '0) begin
                    n_lvl = mul_res;
                    n_seq = SQ_EMIT;
                end
            end
            SQ_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_level = lvl_x[Q_W-1:0];
                    n_out_stage = r_stage;
                    n_seq       = SQ_WAIT;
                end
            end
            default: begin
                n_seq = SQ_WAIT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attack_coeff  <= '0;
            r_decay_coeff   <= '0;
            r_release_coeff <= '0;
            r_sustain       <= Q_W'(ONE_L);
            r_delay_count   <= '0;
            r_hold_count    <= '0;
            r_seq           <= SQ_WAIT;
            r_stage         <= STG_IDLE;
            r_env           <= '0;
            r_count         <= '0;
            r_vel           <= '0;
            r_out_valid     <= 1'b0;
            r_out_level     <= '0;
            r_out_stage     <= STG_IDLE;
            r_cnt           <= '0;
        end else begin
            r_attack_coeff  <= n_attack_coeff;
            r_decay_coeff   <= n_decay_coeff;
            r_release_coeff <= n_release_coeff;
            r_sustain       <= n_sustain;
            r_delay_count   <= n_delay_count;
            r_hold_count    <= n_hold_count;
            r_seq           <= n_seq;
            r_stage         <= n_stage;
            r_env           <= n_env;
            r_count         <= n_count;
            r_vel           <= n_vel;
            r_out_valid     <= n_out_valid;
            r_out_level     <= n_out_level;
            r_out_stage     <= n_out_stage;
            if (mul_load) begin
                r_cnt <= MUL_STEPS;
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - W_CNT'(1);
            end
        end
    end

    // Serial multiplier: one bit of the multiplier operand is consumed per cycle.
    always_ff @(posedge i_clk) begin
        r_base      <= n_base;
        r_cross     <= n_cross;
        r_lvl       <= n_lvl;
        if (mul_load) begin
            r_mcand <= a_mag[W_M-1:0];
            r_mneg  <= mul_a[W_R-1];
            r_hi    <= '0;
            r_lo    <= mul_b;
        end else if (r_cnt != '0) begin
            r_hi <= mul_sum[W_M:1];
            r_lo <= {mul_sum[0], r_lo[W_B-1:1]};
        end
    end

    `DAHDSR_ASSERT_SAME(a_mul_in_product_step, i_clk, i_rst_n, r_cnt != '0, r_seq == SQ_BASE || r_seq == SQ_CROSS || r_seq == SQ_LEVEL, "multiplier running outside a product step")
    `DAHDSR_ASSERT_SAME(a_silent_stage_level, i_clk, i_rst_n, o_env.valid && (o_env.stage == STG_IDLE || o_env.stage == STG_DELAY), o_env.level == '0, "nonzero level reported in idle or delay")
    `DAHDSR_ASSERT_NEXT(a_note_on_start, i_clk, i_rst_n, in_acc && i_cmd.command == CMD_NOTE_ON, r_stage == STG_DELAY || r_stage == STG_ATTACK, "note on did not start delay or attack")

endmodule

/* test/tb_top.sv */
// Self-checking testbench for the DAHDSR envelope generator with random notes, ticks and stalls.
`timescale 1ns / 100ps

module tb_top
    import dahdsr_pkg::*;
;

    localparam logic [CMD_W-1:0] CMD_RSVD = 2'd3;
    localparam longint ONE = 64'sd16777216;
    localparam longint HALF = 64'sd8388608;
    localparam longint ATR = (3 * ONE + 5) / 10;
    localparam longint DTR = (ONE + 5000) / 10000;
    localparam longint EPS = (ONE + 50000) / 100000;
    localparam int unsigned CNT_MAX = 32'h00FF_FFFF;
    localparam int LIMIT = 3000000;
    localparam int ITEMS = 1400;
    localparam int SETTLE = 100;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [Q_W-1:0]   velocity;
    } t_cmd_req;

    typedef struct packed {
        logic [Q_W-1:0] level;
        t_stage         stage;
    } t_env_sample;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    dahdsr_cmd_if cmd_if ();
    dahdsr_env_if env_if ();

    t_cmd_req    cmd_pending_q[$];
    t_env_sample env_expect_q[$];

    logic [COEFF_W-1:0]   cfg_attack, cfg_decay, cfg_release;
    logic [Q_W-1:0]       cfg_sustain;
    logic [CNT_REG_W-1:0] cfg_delay, cfg_hold;

    t_stage      stg;
    longint      env_val;
    longint      note_vel;
    int unsigned stg_cnt;

    int  n_pushed;
    int  n_accepted;
    int  n_errors;
    int  send_gap;
    int  recv_gap;
    int  cycle_cnt;
    bit  no_idle;

    dahdsr_envelope_generator u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd_if),
        .o_env      (env_if)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic longint q_mul(input longint a, input longint b);
        longint p;
        p = a * b;
        if (p >= 0) begin
            return (p + HALF) >>> 24;
        end
        return -((-p + HALF) >>> 24);
    endfunction

    function automatic longint sustain_eff();
        return (longint'(cfg_sustain) > ONE) ? ONE : longint'(cfg_sustain);
    endfunction

    task automatic enter_stage(input t_stage s);
        stg = s;
        stg_cnt = 0;
    endtask

    function automatic bit count_step(input logic [CNT_REG_W-1:0] target);
        if (stg_cnt < CNT_MAX) begin
            stg_cnt++;
        end
        return stg_cnt >= int'({8'd0, target});
    endfunction

    task automatic env_model_step(input logic [CMD_W-1:0] cmd, input logic [Q_W-1:0] vel);
        longint      c;
        longint      s;
        longint      lvl;
        bit          quiet;
        t_env_sample smp;
        quiet = 1'b0;
        lvl = 0;
        case (cmd)
            CMD_NOTE_ON: begin
                note_vel = (longint'(vel) > ONE) ? ONE : longint'(vel);
                enter_stage((cfg_delay != 0) ? STG_DELAY : STG_ATTACK);
                return;
            end
            CMD_NOTE_OFF: begin
                if (stg != STG_IDLE) begin
                    enter_stage(STG_RELEASE);
                end
                return;
            end
            CMD_TICK: ;
            default: return;
        endcase
        case (stg)
            STG_DELAY: begin
                if (count_step(cfg_delay)) begin
                    enter_stage(STG_ATTACK);
                end
                quiet = 1'b1;
            end
            STG_ATTACK: begin
                c = longint'(cfg_attack);
                env_val = q_mul(ONE + ATR, ONE - c) + q_mul(c, env_val);
                if (env_val >= ONE) begin
                    env_val = ONE;
                    enter_stage((cfg_hold != 0) ? STG_HOLD : STG_DECAY);
                end
            end
            STG_HOLD: begin
                env_val = ONE;
                if (count_step(cfg_hold)) begin
                    enter_stage(STG_DECAY);
                end
            end
            STG_DECAY: begin
                c = longint'(cfg_decay);
                s = sustain_eff();
                env_val = q_mul(s - DTR, ONE - c) + q_mul(c, env_val);
                if (env_val <= s + EPS) begin
                    env_val = s;
                    enter_stage(STG_SUSTAIN);
                end
            end
            STG_SUSTAIN: begin
                env_val = sustain_eff();
            end
            STG_RELEASE: begin
                c = longint'(cfg_release);
                env_val = q_mul(-DTR, ONE - c) + q_mul(c, env_val);
                if (env_val <= EPS) begin
                    env_val = 0;
                    enter_stage(STG_IDLE);
                end
            end
            default: begin
                stg = STG_IDLE;
                quiet = 1'b1;
            end
        endcase
        if (!quiet) begin
            lvl = q_mul(env_val, note_vel);
            if (lvl < 0) begin
                lvl = 0;
            end
            if (lvl > ONE) begin
                lvl = ONE;
            end
        end
        smp.level = lvl[Q_W-1:0];
        smp.stage = stg;
        env_expect_q.push_back(smp);
    endtask

    function automatic int idle_len();
        int r;
        if (no_idle) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 150);
    endfunction

    task automatic report_mismatch(input string what);
        n_errors++;
        $display("ERROR at cycle %0d: %s", cycle_cnt, what);
    endtask

    task automatic push_cmd(input logic [CMD_W-1:0] cmd, input logic [Q_W-1:0] vel);
        t_cmd_req req;
        req.command = cmd;
        req.velocity = vel;
        cmd_pending_q.push_back(req);
        n_pushed++;
    endtask

    task automatic push_ticks(input int n);
        repeat (n) push_cmd(CMD_TICK, Q_W'($urandom_range(0, 33554431)));
    endtask

    task automatic cfg_write(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_ATTACK_COEFF:  cfg_attack = data[COEFF_W-1:0];
            CFG_DECAY_COEFF:   cfg_decay = data[COEFF_W-1:0];
            CFG_RELEASE_COEFF: cfg_release = data[COEFF_W-1:0];
            CFG_SUSTAIN_LEVEL: cfg_sustain = data;
            CFG_DELAY_COUNT:   cfg_delay = data[CNT_REG_W-1:0];
            CFG_HOLD_COUNT:    cfg_hold = data[CNT_REG_W-1:0];
            default: ;
        endcase
    endtask

    task automatic write_config(input logic [CFG_DATA_W-1:0] att, input logic [CFG_DATA_W-1:0] dec,
                                input logic [CFG_DATA_W-1:0] rel, input logic [CFG_DATA_W-1:0] sus,
                                input logic [CFG_DATA_W-1:0] dly, input logic [CFG_DATA_W-1:0] hld);
        cfg_write(CFG_ATTACK_COEFF, att);
        cfg_write(CFG_DECAY_COEFF, dec);
        cfg_write(CFG_RELEASE_COEFF, rel);
        cfg_write(CFG_SUSTAIN_LEVEL, sus);
        cfg_write(CFG_DELAY_COUNT, dly);
        cfg_write(CFG_HOLD_COUNT, hld);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        while (n_accepted != n_pushed || env_expect_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic logic [CFG_DATA_W-1:0] rand_coeff();
        int r;
        int k;
        logic [CFG_DATA_W-1:0] top;
        r = $urandom_range(0, 99);
        top = CFG_DATA_W'($urandom_range(0, 1)) << COEFF_W;
        k = $urandom_range(19, 24);
        if (r < 10) begin
            return top;
        end else if (r < 15) begin
            return top | 25'h0FF_FFFF;
        end else if (r < 30) begin
            return top | CFG_DATA_W'($urandom_range(0, 16777215));
        end
        return top | (25'h0FF_FFFF - (CFG_DATA_W'($urandom) & ((25'd1 << k) - 25'd1)));
    endfunction

    function automatic logic [CFG_DATA_W-1:0] rand_sustain();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) begin
            return '0;
        end else if (r < 20) begin
            return 25'h100_0000;
        end else if (r < 30) begin
            return CFG_DATA_W'($urandom_range(16777217, 33554431));
        end
        return CFG_DATA_W'($urandom_range(0, 16777216));
    endfunction

    function automatic logic [CFG_DATA_W-1:0] rand_count();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30) begin
            return '0;
        end else if (r < 85) begin
            return CFG_DATA_W'($urandom_range(1, 5));
        end else if (r < 97) begin
            return CFG_DATA_W'($urandom_range(6, 40));
        end
        return 25'h0FF_FFFF;
    endfunction

    function automatic logic [Q_W-1:0] rand_velocity();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) begin
            return 25'h100_0000;
        end else if (r < 30) begin
            return Q_W'($urandom_range(16777217, 33554431));
        end
        return Q_W'($urandom_range(0, 16777216));
    endfunction

    task automatic gen_phase(input int n_target);
        int start;
        int r;
        start = n_pushed;
        while (n_pushed - start < n_target) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                push_cmd(CMD_NOTE_ON, rand_velocity());
                push_ticks($urandom_range(0, 40));
                if ($urandom_range(0, 2) != 0) begin
                    push_cmd(CMD_NOTE_OFF, Q_W'($urandom_range(0, 33554431)));
                end
                push_ticks($urandom_range(0, 30));
            end else if (r < 80) begin
                push_cmd(CMD_NOTE_ON, rand_velocity());
                push_ticks($urandom_range(0, 12));
                push_cmd(CMD_NOTE_ON, rand_velocity());
                push_ticks($urandom_range(1, 20));
            end else begin
                push_cmd(CMD_W'($urandom_range(0, 3)), Q_W'($urandom_range(0, 33554431)));
            end
        end
    endtask

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= LIMIT) begin
            $display("** dahdsr_envelope_generator: FAILED **");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_cmd_req req;
        if (!i_rst_n) begin
            cmd_if.valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (cmd_if.valid && cmd_if.ready) begin
                env_model_step(cmd_if.command, cmd_if.velocity);
                n_accepted++;
            end
            if (!cmd_if.valid || cmd_if.ready) begin
                if (send_gap != 0 || cmd_pending_q.size() == 0) begin
                    if (send_gap != 0) begin
                        send_gap--;
                    end
                    cmd_if.valid <= 1'b0;
                end else begin
                    req = cmd_pending_q.pop_front();
                    cmd_if.valid <= 1'b1;
                    cmd_if.command <= req.command;
                    cmd_if.velocity <= req.velocity;
                    send_gap = idle_len();
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_env_sample smp;
        bit          took;
        if (!i_rst_n) begin
            env_if.ready <= 1'b0;
            recv_gap = 0;
        end else begin
            took = env_if.valid && env_if.ready;
            if (took) begin
                if (env_expect_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected sample level=%h stage=%0d",
                                              env_if.level, env_if.stage));
                end else begin
                    smp = env_expect_q.pop_front();
                    if (env_if.level !== smp.level) begin
                        report_mismatch($sformatf("level %h, expected %h",
                                                  env_if.level, smp.level));
                    end
                    if (env_if.stage !== smp.stage) begin
                        report_mismatch($sformatf("stage %0d, expected %0d",
                                                  env_if.stage, smp.stage));
                    end
                end
            end
            if (recv_gap != 0) begin
                recv_gap--;
                env_if.ready <= 1'b0;
            end else begin
                env_if.ready <= 1'b1;
                if (took || $urandom_range(0, 7) == 0) begin
                    recv_gap = idle_len();
                end
            end
        end
    end

    initial begin
        int k;
        cmd_if.valid = 1'b0;
        cmd_if.command = CMD_TICK;
        cmd_if.velocity = '0;
        env_if.ready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        cfg_attack = '0;
        cfg_decay = '0;
        cfg_release = '0;
        cfg_sustain = 25'h100_0000;
        cfg_delay = '0;
        cfg_hold = '0;
        stg = STG_IDLE;
        env_val = 0;
        note_vel = 0;
        stg_cnt = 0;
        n_pushed = 0;
        n_accepted = 0;
        n_errors = 0;
        cycle_cnt = 0;
        no_idle = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset register values: instant attack and decay, note-off while idle, reserved code.
        push_cmd(CMD_NOTE_OFF, '0);
        push_cmd(CMD_TICK, '0);
        push_cmd(CMD_RSVD, 25'h1FF_FFFF);
        push_cmd(CMD_NOTE_ON, 25'h1FF_FFFF);
        push_ticks(2);
        push_cmd(CMD_NOTE_ON, '0);
        push_ticks(1);
        push_cmd(CMD_NOTE_OFF, '0);
        push_ticks(1);
        wait_drained();

        // Every stage in order: delay, attack, hold, decay, sustain, then release.
        write_config(25'h040_0000, 25'h010_0000, 25'h010_0000, 25'h080_0000, 25'd2, 25'd2);
        push_cmd(CMD_NOTE_ON, 25'h0C0_0000);
        push_ticks(10);
        push_cmd(CMD_NOTE_OFF, '0);
        push_ticks(5);

        k = 0;
        while (n_pushed < ITEMS) begin
            wait_drained();
            no_idle = 1'b0;
            if (k == 0) begin
                write_config(25'h1FF_FFFF, 25'h1FF_FFFF, 25'h1FF_FFFF, 25'h1FF_FFFF,
                             25'h0FF_FFFF, 25'h0FF_FFFF);
            end else if (k == 1) begin
                write_config('0, '0, '0, '0, '0, '0);
            end else if (k == 2) begin
                write_config('0, rand_coeff(), rand_coeff(), rand_sustain(), '0, 25'h0FF_FFFF);
            end else begin
                write_config(rand_coeff(), rand_coeff(), rand_coeff(), rand_sustain(),
                             rand_count(), rand_count());
            end
            no_idle = (k % 4 == 3);
            gen_phase((k < 3) ? 60 : 140);
            k++;
        end
        wait_drained();
        if (env_expect_q.size() != 0) begin
            report_mismatch($sformatf("%0d samples never arrived", env_expect_q.size()));
        end
        if (n_errors == 0) begin
            $display("** dahdsr_envelope_generator: PASSED **");
        end else begin
            $display("** dahdsr_envelope_generator: FAILED **");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+design
design/dahdsr_pkg.sv
design/dahdsr_cmd_if.sv
design/dahdsr_env_if.sv
design/dahdsr_envelope_generator.sv
test/tb_top.sv
